### rtl/mcr_pkg.sv
`default_nettype none

package mcr_pkg;

    // Input item kinds.
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    // Every iteration emits one point per octant.
    localparam int unsigned POINTS_PER_GROUP = 8;
    localparam int unsigned PHASE_BITS       = $clog2(POINTS_PER_GROUP);
    localparam logic [PHASE_BITS-1:0] LAST_PHASE = PHASE_BITS'(POINTS_PER_GROUP - 1);

    // Number of iterations that can wait between the front and back parts.
    localparam int unsigned QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

### rtl/midpoint_circle_rasterizer_unit.sv
// Channel   Direction  Ports                                         Handshake
// request   in         s_kind s_center_x s_center_y s_radius          s_valid / s_ready
// point     out        m_point_x m_point_y m_last_in_group            m_valid / m_ready
//                      m_circle_done
//
// A start request or a step with no circle running sends nothing on to the queue.
// An active step request yields eight points on the point channel, one point per cycle
// while m_ready stays high, so the single output port sets the sustained step rate.
// Up to two iterations wait in the queue, so the front keeps accepting while points drain.
// Reset is synchronous and active low; it clears the circle's active flag, the queue and
// the output stage.
// A stall on m_ready holds the current point and backs up into the queue, then s_ready.
`default_nettype none

module midpoint_circle_rasterizer_unit #(
    parameter int unsigned RADIUS_BITS = 10,
    parameter int unsigned COORD_BITS  = 12
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_kind,
    input  wire logic signed [COORD_BITS-1:0]  s_center_x,
    input  wire logic signed [COORD_BITS-1:0]  s_center_y,
    input  wire logic        [RADIUS_BITS-1:0] s_radius,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [COORD_BITS:0]         m_point_x,
    output logic signed [COORD_BITS:0]         m_point_y,
    output logic                               m_last_in_group,
    output logic                               m_circle_done
);

    // One queued iteration: done flag, center, and the x and y of that iteration.
    localparam int unsigned GROUP_WIDTH = 2 * (RADIUS_BITS + 1) + 2 * COORD_BITS + 1;

    logic                   push_valid;
    logic                   push_ready;
    logic [GROUP_WIDTH-1:0] push_data;
    logic                   pop_valid;
    logic                   pop_ready;
    logic [GROUP_WIDTH-1:0] pop_data;

    // The front part runs the midpoint recurrence, one iteration per step request,
    // and hands each iteration's coordinates to the queue.
    mcr_front #(
        .RADIUS_BITS (RADIUS_BITS),
        .COORD_BITS  (COORD_BITS),
        .GROUP_WIDTH (GROUP_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_kind     (s_kind),
        .s_center_x (s_center_x),
        .s_center_y (s_center_y),
        .s_radius   (s_radius),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // The queue decouples the recurrence from the point emission.
    mcr_queue #(
        .WIDTH (GROUP_WIDTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // The back part mirrors each iteration into its eight octant points and drives
    // them out through a registered output stage.
    mcr_back #(
        .RADIUS_BITS (RADIUS_BITS),
        .COORD_BITS  (COORD_BITS),
        .GROUP_WIDTH (GROUP_WIDTH)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .pop_valid       (pop_valid),
        .pop_ready       (pop_ready),
        .pop_data        (pop_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_point_x       (m_point_x),
        .m_point_y       (m_point_y),
        .m_last_in_group (m_last_in_group),
        .m_circle_done   (m_circle_done)
    );

`ifndef ASSERT_OFF
    // The end of a circle is only ever flagged on the closing point of a group.
    a_done_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_circle_done || m_last_in_group))
        else $error("circle_done seen on a point that does not close its group");

    // Once a group has started, its eight points leave without gaps.
    a_group_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_in_group) |=> m_valid)
        else $error("gap inside an eight-point group");

    // A group is never popped while the back part is still mid-group with a point pending.
    a_pop_only_at_boundary: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop_valid && pop_ready && m_valid && !m_ready) |-> m_last_in_group)
        else $error("new group loaded while the current one is unfinished");
`endif

endmodule

`default_nettype wire

### rtl/mcr_queue.sv
`default_nettype none

module mcr_queue #(
    parameter int unsigned WIDTH = 47
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int unsigned PTR_BITS = (mcr_pkg::QUEUE_DEPTH > 1) ?
                                       $clog2(mcr_pkg::QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_BITS = $clog2(mcr_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(mcr_pkg::QUEUE_DEPTH);
    localparam logic [PTR_BITS-1:0] LAST_SLOT  = PTR_BITS'(mcr_pkg::QUEUE_DEPTH - 1);

    logic [WIDTH-1:0]    slot_reg [mcr_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != FULL_COUNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### rtl/mcr_front.sv
`default_nettype none

module mcr_front #(
    parameter int unsigned RADIUS_BITS = 10,
    parameter int unsigned COORD_BITS  = 12,
    parameter int unsigned GROUP_WIDTH = 2 * (RADIUS_BITS + 1) + 2 * COORD_BITS + 1
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_kind,
    input  wire logic signed [COORD_BITS-1:0]  s_center_x,
    input  wire logic signed [COORD_BITS-1:0]  s_center_y,
    input  wire logic        [RADIUS_BITS-1:0] s_radius,
    output logic                               push_valid,
    input  wire logic                          push_ready,
    output logic [GROUP_WIDTH-1:0]             push_data
);

    localparam int unsigned XW = RADIUS_BITS + 1;  // running x and y
    localparam int unsigned SW = RADIUS_BITS + 2;  // step terms
    localparam int unsigned DW = RADIUS_BITS + 4;  // error term

    logic                         active_reg, active_next;
    logic signed [XW-1:0]         cur_x_reg, cur_x_next;
    logic signed [XW-1:0]         cur_y_reg, cur_y_next;
    logic        [SW-1:0]         x_step_reg, x_step_next;
    logic        [SW-1:0]         y_step_reg, y_step_next;
    logic signed [DW-1:0]         decision_reg, decision_next;
    logic        [XW-1:0]         twice_radius_reg, twice_radius_next;
    logic signed [COORD_BITS-1:0] held_cx_reg, held_cx_next;
    logic signed [COORD_BITS-1:0] held_cy_reg, held_cy_next;

    logic                         accept;
    logic                         y_adv;
    logic                         x_adv;
    logic signed [DW-1:0]         dec_mid;
    logic        [SW-1:0]         x_step_inc;
    logic                         done;

    assign s_ready    = push_ready;
    assign accept     = s_valid && s_ready;
    assign push_valid = accept && (s_kind == mcr_pkg::KIND_STEP) && active_reg;

    always_comb begin
        active_next       = active_reg;
        cur_x_next        = cur_x_reg;
        cur_y_next        = cur_y_reg;
        x_step_next       = x_step_reg;
        y_step_next       = y_step_reg;
        decision_next     = decision_reg;
        twice_radius_next = twice_radius_reg;
        held_cx_next      = held_cx_reg;
        held_cy_next      = held_cy_reg;

        // One iteration: y advances first, then x is checked on the new error.
        y_adv = decision_reg[DW-1] || (decision_reg == '0);
        dec_mid = y_adv ? decision_reg + $signed({{(DW-SW){1'b0}}, y_step_reg})
                        : decision_reg;
        x_adv = !dec_mid[DW-1] && (dec_mid != '0);
        x_step_inc = x_step_reg + SW'(2);
        done = 1'b0;

        if (accept) begin
            if (s_kind == mcr_pkg::KIND_START) begin
                held_cx_next      = s_center_x;
                held_cy_next      = s_center_y;
                twice_radius_next = {s_radius, 1'b0};
                cur_x_next        = $signed({1'b0, s_radius}) - XW'(1);
                cur_y_next        = '0;
                x_step_next       = SW'(1);
                y_step_next       = SW'(1);
                decision_next     = DW'(1) - $signed({{(DW-XW){1'b0}}, s_radius, 1'b0});
                active_next       = (s_radius != '0);
            end else if (active_reg) begin
                if (y_adv) begin
                    cur_y_next  = cur_y_reg + XW'(1);
                    y_step_next = y_step_reg + SW'(2);
                end
                decision_next = dec_mid;
                if (x_adv) begin
                    cur_x_next    = cur_x_reg - XW'(1);
                    x_step_next   = x_step_inc;
                    decision_next = dec_mid + $signed({{(DW-SW){1'b0}}, x_step_inc})
                                    - $signed({{(DW-XW){1'b0}}, twice_radius_reg});
                end
                done = (cur_x_next < cur_y_next);
                if (done) begin
                    active_next = 1'b0;
                end
            end
        end
    end

    // The group carries its own center so that a later start cannot disturb it.
    assign push_data = {done, held_cy_reg, held_cx_reg, cur_y_reg, cur_x_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_x_reg        <= cur_x_next;
        cur_y_reg        <= cur_y_next;
        x_step_reg       <= x_step_next;
        y_step_reg       <= y_step_next;
        decision_reg     <= decision_next;
        twice_radius_reg <= twice_radius_next;
        held_cx_reg      <= held_cx_next;
        held_cy_reg      <= held_cy_next;
    end

endmodule

`default_nettype wire

### rtl/mcr_back.sv
`default_nettype none

module mcr_back #(
    parameter int unsigned RADIUS_BITS = 10,
    parameter int unsigned COORD_BITS  = 12,
    parameter int unsigned GROUP_WIDTH = 2 * (RADIUS_BITS + 1) + 2 * COORD_BITS + 1
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         pop_valid,
    output logic                              pop_ready,
    input  wire logic [GROUP_WIDTH-1:0]       pop_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [COORD_BITS:0]        m_point_x,
    output logic signed [COORD_BITS:0]        m_point_y,
    output logic                              m_last_in_group,
    output logic                              m_circle_done
);

    localparam int unsigned XW = RADIUS_BITS + 1;
    localparam int unsigned WW = ((COORD_BITS > XW) ? COORD_BITS : XW) + 2;

    logic signed [XW-1:0]         grp_x_reg;
    logic signed [XW-1:0]         grp_y_reg;
    logic signed [COORD_BITS-1:0] grp_cx_reg;
    logic signed [COORD_BITS-1:0] grp_cy_reg;
    logic                         grp_done_reg;
    logic                         busy_reg;
    logic [mcr_pkg::PHASE_BITS-1:0] phase_reg;

    logic                         valid_reg;
    logic signed [COORD_BITS:0]   px_reg;
    logic signed [COORD_BITS:0]   py_reg;
    logic                         last_reg;
    logic                         done_reg;

    logic                         load_out;
    logic                         at_last;
    logic                         do_pop;
    logic signed [WW-1:0]         a_ext;
    logic signed [WW-1:0]         b_ext;
    logic signed [WW-1:0]         cx_ext;
    logic signed [WW-1:0]         cy_ext;
    logic signed [WW-1:0]         px_wide;
    logic signed [WW-1:0]         py_wide;

    assign at_last   = (phase_reg == mcr_pkg::LAST_PHASE);
    assign load_out  = busy_reg && (!valid_reg || m_ready);
    assign pop_ready = !busy_reg || (load_out && at_last);
    assign do_pop    = pop_valid && pop_ready;

    // Phase bit 2 swaps x and y, bit 1 negates the x offset, bit 0 picks +y.
    always_comb begin
        a_ext   = phase_reg[2] ? WW'(grp_y_reg) : WW'(grp_x_reg);
        b_ext   = phase_reg[2] ? WW'(grp_x_reg) : WW'(grp_y_reg);
        cx_ext  = WW'(grp_cx_reg);
        cy_ext  = WW'(grp_cy_reg);
        px_wide = phase_reg[1] ? cx_ext - a_ext : cx_ext + a_ext;
        py_wide = phase_reg[0] ? cy_ext + b_ext : cy_ext - b_ext;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            phase_reg <= '0;
        end else begin
            if (load_out) begin
                valid_reg <= 1'b1;
                phase_reg <= phase_reg + 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
            if (do_pop) begin
                busy_reg  <= 1'b1;
                phase_reg <= '0;
            end else if (load_out && at_last) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_pop) begin
            {grp_done_reg, grp_cy_reg, grp_cx_reg, grp_y_reg, grp_x_reg} <= pop_data;
        end
        if (load_out) begin
            px_reg   <= px_wide[COORD_BITS:0];
            py_reg   <= py_wide[COORD_BITS:0];
            last_reg <= at_last;
            done_reg <= at_last && grp_done_reg;
        end
    end

    assign m_valid         = valid_reg;
    assign m_point_x       = px_reg;
    assign m_point_y       = py_reg;
    assign m_last_in_group = last_reg;
    assign m_circle_done   = done_reg;

endmodule

`default_nettype wire

### tb/tb_midpoint_circle_rasterizer_unit.sv
`default_nettype none

// Self-checking bench for the midpoint circle rasterizer. A start request loads a circle,
// and each step request should produce eight mirrored outline points. The bench keeps
// its own copy of the circle state, predicts every point at the moment a request is
// accepted, and compares each point that leaves the block with the oldest prediction.
module tb_midpoint_circle_rasterizer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned COORD_BITS     = 12;
    localparam int unsigned RADIUS_BITS    = 10;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned DRAIN_CYCLES   = 32;
    localparam int unsigned RANDOM_BUDGET  = 410;

    // One predicted outline pixel, laid out like the point channel.
    typedef struct packed {
        logic signed [COORD_BITS:0] px;
        logic signed [COORD_BITS:0] py;
        logic                       last;
        logic                       done;
    } outline_point_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic                          s_kind;
    logic signed [COORD_BITS-1:0]  s_center_x;
    logic signed [COORD_BITS-1:0]  s_center_y;
    logic        [RADIUS_BITS-1:0] s_radius;
    logic                          m_valid;
    logic                          m_ready;
    logic signed [COORD_BITS:0]    m_point_x;
    logic signed [COORD_BITS:0]    m_point_y;
    logic                          m_last_in_group;
    logic                          m_circle_done;

    midpoint_circle_rasterizer_unit #(
        .RADIUS_BITS(RADIUS_BITS),
        .COORD_BITS (COORD_BITS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_center_x     (s_center_x),
        .s_center_y     (s_center_y),
        .s_radius       (s_radius),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_point_x      (m_point_x),
        .m_point_y      (m_point_y),
        .m_last_in_group(m_last_in_group),
        .m_circle_done  (m_circle_done)
    );

    // The bench's own copy of the circle state, kept at the block's widths.
    logic                          circle_live;
    logic signed [10:0]            walk_x;
    logic signed [10:0]            walk_y;
    logic        [11:0]            x_inc;
    logic        [11:0]            y_inc;
    logic signed [13:0]            midpoint_err;
    logic        [10:0]            diameter;
    logic signed [COORD_BITS-1:0]  origin_x;
    logic signed [COORD_BITS-1:0]  origin_y;

    // Points predicted but not yet seen on the point channel, oldest first.
    outline_point_t pending_points[$];

    int unsigned sent_items;
    int unsigned mismatch_count;
    int unsigned quiet_cycles;
    int unsigned point_index;

    // When set, neither side inserts idle cycles, so the block runs at full rate.
    bit steady;

    // Free-running clock with a 2 ns period.
    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // Idle lengths: mostly none or short, now and then a long pause.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady) begin
            return 0;
        end
        if (roll < 45) begin
            return 0;
        end else if (roll < 88) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("%s", msg);
    endtask

    // Update the predicted circle state for one accepted request and queue the points
    // that a step is expected to produce. The midpoint update matches the integer
    // algorithm: y advances while the error is not positive, then x advances if the
    // error has turned positive.
    task automatic predict_outline(input logic kind, input logic signed [COORD_BITS-1:0] cx,
                                   input logic signed [COORD_BITS-1:0] cy,
                                   input logic [RADIUS_BITS-1:0] rad);
        int             rr;
        int             x;
        int             y;
        int             ox;
        int             oy;
        int             d;
        int             xi;
        int             yi;
        int             ctr_x;
        int             ctr_y;
        int             dx;
        int             dy;
        logic           finished;
        outline_point_t pt;
        if (kind == mcr_pkg::KIND_START) begin
            rr           = int'(rad);
            origin_x     = cx;
            origin_y     = cy;
            diameter     = 11'(2 * rr);
            walk_x       = 11'(rr - 1);
            walk_y       = '0;
            x_inc        = 12'd1;
            y_inc        = 12'd1;
            midpoint_err = 14'(1 - 2 * rr);
            circle_live  = (rr - 1 >= 0);
            return;
        end
        if (!circle_live) begin
            return;
        end
        x  = int'(walk_x);
        y  = int'(walk_y);
        ox = x;
        oy = y;
        d  = int'(midpoint_err);
        xi = int'(x_inc);
        yi = int'(y_inc);
        if (d <= 0) begin
            y  = y + 1;
            d  = d + yi;
            yi = yi + 2;
        end
        if (d > 0) begin
            x  = x - 1;
            xi = xi + 2;
            d  = d + xi - int'(diameter);
        end
        finished     = !(x >= y);
        walk_x       = 11'(x);
        walk_y       = 11'(y);
        x_inc        = 12'(xi);
        y_inc        = 12'(yi);
        midpoint_err = 14'(d);
        if (finished) begin
            circle_live = 1'b0;
        end
        ctr_x = int'(origin_x);
        ctr_y = int'(origin_y);
        // Points 0..3 mirror (x, y) and points 4..7 mirror (y, x). Bit 1 of the index
        // negates the x offset and bit 0 selects the positive y offset.
        for (int k = 0; k < mcr_pkg::POINTS_PER_GROUP; k++) begin
            dx      = (k < 4) ? ox : oy;
            dy      = (k < 4) ? oy : ox;
            pt.px   = (COORD_BITS + 1)'(ctr_x + ((k & 2) != 0 ? -dx : dx));
            pt.py   = (COORD_BITS + 1)'(ctr_y + ((k & 1) != 0 ? dy : -dy));
            pt.last = (k == mcr_pkg::POINTS_PER_GROUP - 1);
            pt.done = (k == mcr_pkg::POINTS_PER_GROUP - 1) && finished;
            pending_points.push_back(pt);
        end
    endtask

    // Drive one request from a falling edge, hold it until the block takes it, and
    // record its prediction at the accepting edge. Valid is only lowered when a gap
    // is inserted, so back-to-back requests keep it high without a glitch.
    task automatic send_request(input logic kind, input logic signed [COORD_BITS-1:0] cx,
                                input logic signed [COORD_BITS-1:0] cy,
                                input logic [RADIUS_BITS-1:0] rad);
        int unsigned gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_kind     <= kind;
        s_center_x <= cx;
        s_center_y <= cy;
        s_radius   <= rad;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        predict_outline(kind, cx, cy, rad);
        sent_items++;
    endtask

    task automatic send_start(input logic signed [COORD_BITS-1:0] cx,
                              input logic signed [COORD_BITS-1:0] cy,
                              input logic [RADIUS_BITS-1:0] rad);
        send_request(mcr_pkg::KIND_START, cx, cy, rad);
    endtask

    // Steps carry random junk in the center and radius fields, which the block must ignore.
    task automatic send_step();
        send_request(mcr_pkg::KIND_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                     RADIUS_BITS'($urandom));
    endtask

    // A step right after reset has no circle to advance and must produce nothing.
    task automatic test_idle_step();
        send_step();
    endtask

    // A zero radius never becomes active, so the steps that follow are silent.
    task automatic test_zero_radius();
        send_start(12'sd100, -12'sd100, 10'd0);
        send_step();
        send_step();
    endtask

    // Radius one finishes on its first iteration; the second step finds no circle.
    task automatic test_unit_radius();
        send_start(12'sd0, 12'sd0, 10'd1);
        send_step();
        send_step();
    endtask

    // The largest radius at both corners of the coordinate range reaches the widest
    // point values. The second start abandons the first circle while it is running.
    task automatic test_extreme_centers();
        send_start(-12'sd2048, -12'sd2048, 10'd1023);
        send_step();
        send_step();
        send_start(12'sd2047, 12'sd2047, 10'd1023);
        send_step();
        send_step();
        send_start(12'sd2047, -12'sd2048, 10'd2);
        send_step();
        send_step();
    endtask

    // A zero-radius start while a circle is running must cancel it without output.
    task automatic test_restart_while_active();
        send_start(-12'sd7, 12'sd9, 10'd5);
        send_step();
        send_start(12'sd3, 12'sd3, 10'd0);
        send_step();
    endtask

    // Mostly complete circles of small radius, with some medium ones, some large ones
    // that are abandoned after a few iterations, some early restarts and stray steps.
    task automatic test_random_circles(input int unsigned budget);
        int unsigned roll;
        int unsigned rad;
        int unsigned steps_left;
        while (sent_items < budget) begin
            roll = $urandom_range(0, 99);
            if (roll < 78) begin
                rad = $urandom_range(1, 24);
            end else if (roll < 94) begin
                rad = $urandom_range(25, 120);
            end else begin
                rad = $urandom_range(0, 1023);
            end
            send_start(COORD_BITS'($urandom), COORD_BITS'($urandom), RADIUS_BITS'(rad));
            steps_left = (rad > 120) ? $urandom_range(1, 24) : 1000;
            if ($urandom_range(0, 99) < 12) begin
                steps_left = $urandom_range(0, 6);
            end
            while (circle_live && steps_left > 0) begin
                send_step();
                steps_left--;
            end
            if ($urandom_range(0, 99) < 20) begin
                send_step();
            end
        end
    endtask

    // Unstructured requests: random kinds and fields over the full ranges.
    task automatic test_random_noise(input int unsigned count);
        repeat (count) begin
            if ($urandom_range(0, 99) < 70) begin
                send_step();
            end else begin
                send_start(COORD_BITS'($urandom), COORD_BITS'($urandom),
                           RADIUS_BITS'($urandom));
            end
        end
    endtask

    // Full-rate stream with no idle cycles on either side.
    task automatic test_steady_stream();
        steady = 1'b1;
        send_start(COORD_BITS'($urandom), COORD_BITS'($urandom), 10'd30);
        repeat (24) send_step();
        send_start(COORD_BITS'($urandom), COORD_BITS'($urandom), 10'd3);
        while (circle_live) begin
            send_step();
        end
        steady = 1'b0;
    endtask

    // Point channel receiver: ready drops for random stretches and then stays high
    // for a random burst. Each falling edge carries at most one update of ready.
    initial begin : point_receiver
        int unsigned stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            repeat ($urandom_range(0, 15)) @(negedge aclk);
        end
    end

    // Every accepted point is matched against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_points.size() == 0) begin
                flag_mismatch($sformatf("unexpected point %0d: (%0d,%0d) last=%b done=%b",
                              point_index, m_point_x, m_point_y, m_last_in_group,
                              m_circle_done));
            end else begin
                automatic outline_point_t want = pending_points.pop_front();
                if (m_point_x !== want.px || m_point_y !== want.py ||
                    m_last_in_group !== want.last || m_circle_done !== want.done) begin
                    flag_mismatch($sformatf(
                        "point %0d: got (%0d,%0d) last=%b done=%b, want (%0d,%0d) last=%b done=%b",
                        point_index, m_point_x, m_point_y, m_last_in_group, m_circle_done,
                        want.px, want.py, want.last, want.done));
                end
            end
            point_index++;
        end
    end

    // The run is abandoned if neither channel moves a request or a point for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("[midpoint_circle_rasterizer_unit] ERROR");
                $finish;
            end
        end
    end

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_kind         = mcr_pkg::KIND_START;
        s_center_x     = '0;
        s_center_y     = '0;
        s_radius       = '0;
        m_ready        = 1'b0;
        steady         = 1'b0;
        sent_items     = 0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        point_index    = 0;
        circle_live    = 1'b0;
        walk_x         = '0;
        walk_y         = '0;
        x_inc          = '0;
        y_inc          = '0;
        midpoint_err   = '0;
        diameter       = '0;
        origin_x       = '0;
        origin_y       = '0;

        // Hold reset low at the start and release it away from the rising edge.
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_idle_step();
        test_zero_radius();
        test_unit_radius();
        test_extreme_centers();
        test_restart_while_active();
        test_random_circles(RANDOM_BUDGET);
        test_random_noise(40);
        test_steady_stream();

        @(negedge aclk);
        s_valid <= 1'b0;

        // Let every predicted point drain, then watch a while longer for strays.
        while (pending_points.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("[midpoint_circle_rasterizer_unit] OK");
        end else begin
            $display("[midpoint_circle_rasterizer_unit] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
